/* src/rdm_pkg.sv */
package rdm_pkg;

	localparam int RespBytes = 52;
	localparam int RespIdxW = $clog2(RespBytes);
	localparam int RomBytes = 64;
	localparam int RomIdxW = $clog2(RomBytes);

	localparam logic [7:0] SubStartRdm = 8'h01;
	localparam logic [7:0] CcGet = 8'h20;
	localparam logic [7:0] CcSet = 8'h30;
	localparam logic [7:0] CcGetResp = 8'h21;
	localparam logic [7:0] CcSetResp = 8'h31;
	localparam logic [7:0] RtAck = 8'h00;
	localparam logic [7:0] RtNack = 8'h02;
	localparam logic [15:0] NrUnknownPid = 16'h0000;
	localparam logic [15:0] NrFormat = 16'h0001;
	localparam logic [15:0] NrClass = 16'h0005;
	localparam logic [15:0] NrRange = 16'h0006;
	localparam logic [15:0] NrSubdev = 16'h0009;
	localparam logic [15:0] ChecksumSeed = 16'h00CC;
	localparam logic [9:0] MaxStartAddr = 10'd512;

	localparam logic [15:0] PidSupported = 16'h0050;
	localparam logic [15:0] PidDevInfo = 16'h0060;
	localparam logic [15:0] PidModel = 16'h0080;
	localparam logic [15:0] PidMfr = 16'h0081;
	localparam logic [15:0] PidSwLabel = 16'h00C0;
	localparam logic [15:0] PidPers = 16'h00E0;
	localparam logic [15:0] PidPersDesc = 16'h00E1;
	localparam logic [15:0] PidStartAddr = 16'h00F0;
	localparam logic [15:0] PidSlotInfo = 16'h0120;
	localparam logic [15:0] PidIdentify = 16'h1000;

	localparam logic [1:0] CfgMfr = 2'd0;
	localparam logic [1:0] CfgDev = 2'd1;
	localparam logic [1:0] CfgSw = 2'd2;
	localparam logic [1:0] CfgStart = 2'd3;

	typedef enum logic [4:0] {
		ST_RX    = 5'b00001,
		ST_BUILD = 5'b00010,
		ST_SUM   = 5'b00100,
		ST_TAIL  = 5'b01000,
		ST_SEND  = 5'b10000
	} state_t;

	typedef struct packed {
		logic [47:0] dest_uid;
		logic [47:0] src_uid;
		logic [7:0]  transaction_num;
		logic [7:0]  cmd_class;
		logic [15:0] sub_device_id;
		logic [15:0] pid_value;
		logic [7:0]  data_len;
		logic [15:0] data_head;
	} req_t;

	function automatic logic [7:0] label_rom(input logic [RomIdxW-1:0] a);
		logic [7:0] r;
		begin
			unique case (a)
				6'd0: r = "L";  6'd1: r = "i";  6'd2: r = "g";  6'd3: r = "h";
				6'd4: r = "t";  6'd5: r = " ";  6'd6: r = "T";  6'd7: r = "o";
				6'd8: r = "w";  6'd9: r = "e";  6'd10: r = "r"; 6'd11: r = "A";
				6'd12: r = "c"; 6'd13: r = "m"; 6'd14: r = "e"; 6'd15: r = "1";
				6'd16: r = "."; 6'd17: r = "0"; 6'd18: r = "D"; 6'd19: r = "e";
				6'd20: r = "f"; 6'd21: r = "a"; 6'd22: r = "u"; 6'd23: r = "l";
				6'd24: r = "t"; 6'd25: r = " "; 6'd26: r = "4"; 6'd27: r = "c";
				6'd28: r = "h";
				default: r = 8'h00;
			endcase
			return r;
		end
	endfunction

endpackage

/* src/rdm_rx.sv */
module rdm_rx import rdm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	input  logic       rx_last,
	output req_t       req,
	output logic [7:0] sub_start,
	output logic       frame_done,
	output logic       frame_long
);

	logic [7:0] count_q;
	req_t req_q;
	logic [7:0] sub_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			req_q <= '0;
			sub_q <= '0;
		end else if (take) begin
			if (count_q == 8'd0) begin
				sub_q <= rx_byte;
				req_q <= '0;
			end else if (count_q >= 8'd2 && count_q <= 8'd7)
				req_q.dest_uid <= {req_q.dest_uid[39:0], rx_byte};
			else if (count_q >= 8'd8 && count_q <= 8'd13)
				req_q.src_uid <= {req_q.src_uid[39:0], rx_byte};
			else if (count_q == 8'd14)
				req_q.transaction_num <= rx_byte;
			else if (count_q == 8'd17 || count_q == 8'd18)
				req_q.sub_device_id <= {req_q.sub_device_id[7:0], rx_byte};
			else if (count_q == 8'd19)
				req_q.cmd_class <= rx_byte;
			else if (count_q == 8'd20 || count_q == 8'd21)
				req_q.pid_value <= {req_q.pid_value[7:0], rx_byte};
			else if (count_q == 8'd22)
				req_q.data_len <= rx_byte;
			else if (count_q == 8'd23)
				req_q.data_head <= {rx_byte, 8'h00};
			else if (count_q == 8'd24)
				req_q.data_head <= {req_q.data_head[15:8], rx_byte};
			if (rx_last)
				count_q <= '0;
			else if (count_q != 8'hFF)
				count_q <= count_q + 8'd1;
		end
	end

	always_comb begin
		req = req_q;
		sub_start = sub_q;
		if (count_q == 8'd0) begin
			req = '0;
			sub_start = rx_byte;
		end else if (count_q >= 8'd2 && count_q <= 8'd7)
			req.dest_uid = {req_q.dest_uid[39:0], rx_byte};
		else if (count_q >= 8'd8 && count_q <= 8'd13)
			req.src_uid = {req_q.src_uid[39:0], rx_byte};
		else if (count_q == 8'd14)
			req.transaction_num = rx_byte;
		else if (count_q == 8'd17 || count_q == 8'd18)
			req.sub_device_id = {req_q.sub_device_id[7:0], rx_byte};
		else if (count_q == 8'd19)
			req.cmd_class = rx_byte;
		else if (count_q == 8'd20 || count_q == 8'd21)
			req.pid_value = {req_q.pid_value[7:0], rx_byte};
		else if (count_q == 8'd22)
			req.data_len = rx_byte;
		else if (count_q == 8'd23)
			req.data_head = {rx_byte, 8'h00};
		else if (count_q == 8'd24)
			req.data_head = {req_q.data_head[15:8], rx_byte};
	end

	assign frame_done = take && rx_last;
	assign frame_long = (count_q >= 8'd22);

endmodule

/* src/rdm_resp.sv */
module rdm_resp import rdm_pkg::*; (
	input  logic                clk,
	input  req_t                req,
	input  logic [15:0]         sw_rev,
	input  logic [9:0]          dmx_start,
	input  logic                ident,
	input  logic [RespIdxW-1:0] idx,
	output logic [7:0]          val,
	output logic [7:0]          pdl
);

	logic nack;
	logic set_c;
	logic [7:0] d0;
	logic [15:0] reason;
	logic [7:0] pd;
	logic [7:0] p;
	logic [7:0] hdr;
	logic [7:0] cc;

	assign set_c = (req.cmd_class == CcSet);
	assign d0 = req.data_head[15:8];

	always_comb begin
		nack = 1'b0;
		reason = NrUnknownPid;
		pdl = 8'd0;
		cc = set_c ? CcSetResp : CcGetResp;
		if (req.sub_device_id != 16'd0) begin
			nack = 1'b1; reason = NrSubdev;
		end else begin
			unique case (req.pid_value)
				PidSupported, PidDevInfo, PidModel, PidMfr, PidSwLabel, PidSlotInfo: begin
					if (set_c) begin
						nack = 1'b1; reason = NrClass;
					end else if (req.data_len != 8'd0) begin
						nack = 1'b1; reason = NrFormat;
					end
					unique case (req.pid_value)
						PidSupported: pdl = 8'd10;
						PidDevInfo:   pdl = 8'h13;
						PidModel:     pdl = 8'd11;
						PidMfr:       pdl = 8'd4;
						PidSwLabel:   pdl = 8'd3;
						default:      pdl = 8'd20;
					endcase
					cc = CcGetResp;
				end
				PidPers: begin
					if (set_c) begin
						if (req.data_len != 8'd1) begin
							nack = 1'b1; reason = NrFormat;
						end else if (d0 != 8'd1) begin
							nack = 1'b1; reason = NrRange;
						end
						pdl = 8'd0;
					end else begin
						if (req.data_len != 8'd0) begin
							nack = 1'b1; reason = NrFormat;
						end
						pdl = 8'd2;
					end
				end
				PidPersDesc: begin
					if (set_c) begin
						nack = 1'b1; reason = NrClass;
					end else if (req.data_len != 8'd1) begin
						nack = 1'b1; reason = NrFormat;
					end else if (d0 != 8'd1) begin
						nack = 1'b1; reason = NrRange;
					end
					pdl = 8'd14;
					cc = CcGetResp;
				end
				PidStartAddr: begin
					if (set_c) begin
						if (req.data_len != 8'd2) begin
							nack = 1'b1; reason = NrFormat;
						end else if (req.data_head == 16'd0 || req.data_head > 16'd512) begin
							nack = 1'b1; reason = NrRange;
						end
						pdl = 8'd0;
					end else begin
						if (req.data_len != 8'd0) begin
							nack = 1'b1; reason = NrFormat;
						end
						pdl = 8'd2;
					end
				end
				PidIdentify: begin
					if (set_c) begin
						if (req.data_len != 8'd1) begin
							nack = 1'b1; reason = NrFormat;
						end else if (d0 > 8'd1) begin
							nack = 1'b1; reason = NrRange;
						end
						pdl = 8'd0;
					end else begin
						if (req.data_len != 8'd0) begin
							nack = 1'b1; reason = NrFormat;
						end
						pdl = 8'd1;
					end
				end
				default: nack = 1'b1;
			endcase
		end
		if (nack) begin
			pdl = 8'd2;
			cc = (req.cmd_class == CcGet) ? CcGetResp : CcSetResp;
		end
	end

	assign p = 8'(idx - RespIdxW'(23));

	always_comb begin
		pd = 8'h00;
		if (nack)
			pd = (p == 8'd0) ? reason[15:8] : reason[7:0];
		else begin
			unique case (req.pid_value)
				PidSupported: begin
					unique case (p)
						8'd1: pd = 8'h80; 8'd3: pd = 8'h81; 8'd5: pd = 8'hE0;
						8'd7: pd = 8'hE1; 8'd8: pd = 8'h01; 8'd9: pd = 8'h20;
						default: pd = 8'h00;
					endcase
				end
				PidDevInfo: begin
					unique case (p)
						8'd0: pd = 8'h01; 8'd4: pd = 8'h01; 8'd5: pd = 8'h01;
						8'd8: pd = sw_rev[15:8]; 8'd9: pd = sw_rev[7:0];
						8'd11: pd = 8'h04; 8'd12: pd = 8'h01; 8'd13: pd = 8'h01;
						8'd14: pd = {6'd0, dmx_start[9:8]};
						8'd15: pd = dmx_start[7:0];
						default: pd = 8'h00;
					endcase
				end
				PidModel:   pd = label_rom(p[RomIdxW-1:0]);
				PidMfr:     pd = label_rom(RomIdxW'(p + 8'd11));
				PidSwLabel: pd = label_rom(RomIdxW'(p + 8'd15));
				PidSlotInfo: begin
					unique case (p)
						8'd6: pd = 8'h01; 8'd11: pd = 8'h02; 8'd16: pd = 8'h03;
						8'd3: pd = 8'h02; 8'd4: pd = 8'h05;
						8'd8: pd = 8'h02; 8'd9: pd = 8'h11;
						8'd13: pd = 8'h02; 8'd14: pd = 8'h06;
						8'd18: pd = 8'hFF; 8'd19: pd = 8'hFF;
						default: pd = 8'h00;
					endcase
				end
				PidPers:      pd = 8'h01;
				PidPersDesc: begin
					if (p == 8'd0) pd = 8'h01;
					else if (p == 8'd1) pd = 8'h00;
					else if (p == 8'd2) pd = 8'h04;
					else pd = label_rom(RomIdxW'(p + 8'd15));
				end
				PidStartAddr: pd = (p == 8'd0) ? {6'd0, dmx_start[9:8]} : dmx_start[7:0];
				PidIdentify:  pd = {7'd0, ident};
				default:      pd = 8'h00;
			endcase
		end
	end

	always_comb begin
		hdr = 8'h00;
		if (idx == RespIdxW'(0)) hdr = SubStartRdm;
		else if (idx == RespIdxW'(1)) hdr = 8'(pdl + 8'd24);
		else if (idx >= RespIdxW'(2) && idx <= RespIdxW'(7))
			hdr = req.src_uid[8*(7-idx[2:0]) +: 8];
		else if (idx >= RespIdxW'(8) && idx <= RespIdxW'(13))
			hdr = req.dest_uid[8*(13-idx) +: 8];
		else if (idx == RespIdxW'(14)) hdr = req.transaction_num;
		else if (idx == RespIdxW'(15)) hdr = nack ? RtNack : RtAck;
		else if (idx == RespIdxW'(19)) hdr = cc;
		else if (idx == RespIdxW'(20)) hdr = req.pid_value[15:8];
		else if (idx == RespIdxW'(21)) hdr = req.pid_value[7:0];
		else if (idx == RespIdxW'(22)) hdr = pdl;
		else if (idx >= RespIdxW'(23)) hdr = pd;
	end

	always_ff @(posedge clk) begin
		val <= hdr;
	end

endmodule

/* src/rdm_responder_unit.sv */
// RDM responder. Request bytes enter on start with rx_byte/rx_last, one word
// per accepted cycle, beginning at the sub-start code. Configuration goes
// through wr_en/wr_index/wr_data; writing register 3 also reloads the DMX
// start address (0 loads 1, above 512 loads 512).
// A request byte that is not the last is captured and the block stays idle.
// On the last byte the frame is decoded; a dropped, short or broadcast frame
// leaves the block idle, ready for the next byte in the following cycle. An
// answered frame builds the first L-1 response bytes (L = length byte) into a
// local buffer one byte a cycle through a shared byte generator, sums bytes
// 0..L-2 with a shared 16-bit adder, appends the two checksum bytes, then
// reads the buffer out and streams L+1 words on tx_valid, one per cycle,
// with tx_last on the final one. busy stays high after the last request
// byte until the readout ends, with L at most 44; the final word shows in
// the first cycle with busy low.
// identify_on and start_address show the current state at all times and
// already hold a set's result while its response streams.
// Reset clears the capture state, loads start address 1, identify off,
// and returns to idle. The receiver cannot stall; every word shows for
// exactly one cycle.
module rdm_responder_unit import rdm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  rx_byte,
	input  logic        rx_last,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        tx_last,
	output logic        identify_on,
	output logic [9:0]  start_address
);

	state_t state_q;
	logic take;
	req_t req_w;
	req_t req_q;
	logic [7:0] sub_w;
	logic frame_done, frame_long;
	logic [15:0] mfr_q, sw_q;
	logic [31:0] dev_q;
	logic [9:0] dmx_q;
	logic ident_q;
	logic [RespIdxW-1:0] idx_q;
	logic [RespIdxW-1:0] wr_idx_q;
	logic wr_pend_q;
	logic [7:0] gen_val, pdl;
	logic [7:0] mem_q [RespBytes];
	logic [7:0] rd_q;
	logic [7:0] len_q;
	logic [15:0] sum_q;
	logic own, bcast, apply;
	logic [9:0] wr_clip;
	logic [RespIdxW-1:0] rd_idx;

	assign take = start && !busy;
	assign busy = (state_q != ST_RX);

	rdm_rx u_rx (
		.clk, .arst_n, .take, .rx_byte, .rx_last,
		.req(req_w), .sub_start(sub_w), .frame_done, .frame_long
	);

	rdm_resp u_resp (
		.clk, .req(req_q), .sw_rev(sw_q), .dmx_start(dmx_q), .ident(ident_q),
		.idx(idx_q), .val(gen_val), .pdl
	);

	assign own = (req_w.dest_uid == {mfr_q, dev_q});
	assign bcast = (req_w.dest_uid == 48'hFFFF_FFFF_FFFF) ||
		(req_w.dest_uid == {mfr_q, 32'hFFFF_FFFF});
	assign apply = frame_done && frame_long && (sub_w == SubStartRdm) && (own || bcast);

	assign wr_clip = (wr_data[9:0] == 10'd0) ? 10'd1 :
		((wr_data[9:0] > MaxStartAddr) ? MaxStartAddr : wr_data[9:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mfr_q <= '0; dev_q <= '0; sw_q <= '0;
			dmx_q <= 10'd1; ident_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					CfgMfr:   mfr_q <= wr_data[15:0];
					CfgDev:   dev_q <= wr_data;
					CfgSw:    sw_q <= wr_data[15:0];
					CfgStart: dmx_q <= wr_clip;
					default:  ;
				endcase
			end
			if (apply && req_w.sub_device_id == 16'd0 && req_w.cmd_class == CcSet) begin
				if (req_w.pid_value == PidStartAddr && req_w.data_len == 8'd2 &&
					req_w.data_head != 16'd0 && req_w.data_head <= 16'd512)
					dmx_q <= req_w.data_head[9:0];
				if (req_w.pid_value == PidIdentify && req_w.data_len == 8'd1 &&
					req_w.data_head[15:8] <= 8'd1)
					ident_q <= req_w.data_head[8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RX;
			idx_q <= '0;
			wr_pend_q <= 1'b0;
			wr_idx_q <= '0;
			len_q <= '0;
			sum_q <= '0;
		end else begin
			unique case (state_q)
				ST_RX: begin
					if (apply && own) begin
						state_q <= ST_BUILD;
						idx_q <= '0;
						wr_pend_q <= 1'b0;
					end
				end
				ST_BUILD: begin
					wr_pend_q <= 1'b1;
					wr_idx_q <= idx_q;
					len_q <= 8'(pdl + 8'd24);
					if (idx_q == RespIdxW'(pdl + 8'd22)) begin
						state_q <= ST_SUM;
						idx_q <= '0;
						sum_q <= ChecksumSeed;
					end else
						idx_q <= idx_q + RespIdxW'(1);
				end
				ST_SUM: begin
					wr_pend_q <= 1'b0;
					if (idx_q > RespIdxW'(1) || (idx_q == RespIdxW'(1) && wr_pend_q == 1'b0))
						sum_q <= sum_q + {8'd0, rd_q};
					if (idx_q == RespIdxW'(len_q - 8'd1)) begin
						state_q <= ST_TAIL;
						idx_q <= '0;
					end else
						idx_q <= idx_q + RespIdxW'(1);
				end
				ST_TAIL: begin
					idx_q <= idx_q + RespIdxW'(1);
					if (idx_q == RespIdxW'(1)) begin
						state_q <= ST_SEND;
						idx_q <= '0;
					end
				end
				ST_SEND: begin
					idx_q <= idx_q + RespIdxW'(1);
					if (idx_q == RespIdxW'(len_q + 8'd1)) state_q <= ST_RX;
				end
				default: state_q <= ST_RX;
			endcase
		end
	end

	assign rd_idx = idx_q;

	always_ff @(posedge clk) begin
		if (wr_pend_q && state_q == ST_SUM && idx_q == RespIdxW'(0))
			mem_q[wr_idx_q] <= gen_val;
		else if (state_q == ST_BUILD && wr_pend_q)
			mem_q[wr_idx_q] <= gen_val;
		else if (state_q == ST_TAIL)
			mem_q[RespIdxW'(len_q + 8'(idx_q) - 8'd1)] <=
				(idx_q == RespIdxW'(0)) ? sum_q[15:8] : sum_q[7:0];
		rd_q <= mem_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid <= 1'b0;
			tx_last <= 1'b0;
		end else begin
			tx_valid <= (state_q == ST_SEND) && (idx_q != RespIdxW'(0));
			tx_last <= (state_q == ST_SEND) && (idx_q == RespIdxW'(len_q + 8'd1)) &&
				(idx_q != RespIdxW'(0));
		end
	end

	always_ff @(posedge clk) begin
		tx_byte <= rd_q;
	end

	always_ff @(posedge clk) begin
		req_q <= take ? req_w : req_q;
	end

	assign identify_on = ident_q;
	assign start_address = dmx_q;

endmodule

/* src/rdm_checker.sv */
module rdm_checker import rdm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       tx_valid,
	input logic       tx_last,
	input logic [9:0] start_address
);

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tx_last |-> tx_valid) else $error("tx_last without tx_valid");

	a_tx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_last |=> busy || tx_valid)
		else $error("stream ended early");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		start_address != 10'd0 && start_address <= MaxStartAddr)
		else $error("start address out of range");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		tx_last |=> !tx_last) else $error("back to back tx_last");

endmodule

bind rdm_responder_unit rdm_checker u_rdm_checker (
	.clk, .arst_n, .start, .busy, .tx_valid, .tx_last, .start_address
);

/* test/tb_rdm_responder_unit.sv */
`timescale 1ns / 1ps

module tb_rdm_responder_unit;
	import rdm_pkg::*;

	typedef struct {
		logic [7:0] b;
		logic       l;
	} req_word_t;

	typedef struct {
		logic [7:0] b;
		logic       l;
		logic       ident;
		logic [9:0] addr;
	} rsp_word_t;

	localparam string LabelText = "Light TowerAcme1.0Default 4ch";

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  rx_byte;
	logic        rx_last;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        tx_last;
	logic        identify_on;
	logic [9:0]  start_address;

	req_word_t req_words_q[$];
	rsp_word_t rsp_words_q[$];
	int        mismatches;
	int        burst_left;
	int        gap_left;
	int        phase_bytes;

	// responder shadow state
	logic [15:0] own_mfr;
	logic [31:0] own_dev;
	logic [15:0] sw_rev;
	logic [7:0]  rx_cnt;
	logic [7:0]  cap_ss;
	logic [47:0] cap_dst;
	logic [47:0] cap_src;
	logic [7:0]  cap_tn;
	logic [7:0]  cap_cc;
	logic [15:0] cap_sd;
	logic [15:0] cap_pid;
	logic [7:0]  cap_dl;
	logic [15:0] cap_head;
	logic [9:0]  dmx_addr;
	logic        ident_flag;
	logic [7:0]  rsp_buf[0:63];

	rdm_responder_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.rx_byte(rx_byte),
		.rx_last(rx_last),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.tx_last(tx_last),
		.identify_on(identify_on),
		.start_address(start_address)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void pd(input int i, input logic [7:0] v);
		rsp_buf[23 + i] = v;
	endfunction

	function automatic void pd16(input int i, input logic [15:0] v);
		pd(i, v[15:8]);
		pd(i + 1, v[7:0]);
	endfunction

	function automatic void pd_label(input int i, input int at, input int n);
		for (int k = 0; k < n; k++)
			pd(i + k, LabelText[at + k]);
	endfunction

	function automatic void put_header(input logic [7:0] rt, input logic [7:0] cc,
			input logic [15:0] pid);
		rsp_buf[0] = SubStartRdm;
		for (int k = 0; k < 6; k++) begin
			rsp_buf[2 + k] = cap_src[40 - 8 * k +: 8];
			rsp_buf[8 + k] = cap_dst[40 - 8 * k +: 8];
		end
		rsp_buf[14] = cap_tn;
		rsp_buf[15] = rt;
		rsp_buf[16] = 8'h00;
		rsp_buf[17] = 8'h00;
		rsp_buf[18] = 8'h00;
		rsp_buf[19] = cc;
		rsp_buf[20] = pid[15:8];
		rsp_buf[21] = pid[7:0];
	endfunction

	function automatic int seal(input int pdl, input logic bc);
		int len;
		logic [15:0] sum;
		len = pdl + 24;
		sum = ChecksumSeed;
		if (bc)
			return 0;
		rsp_buf[22] = pdl[7:0];
		rsp_buf[1] = len[7:0];
		for (int k = 0; k + 1 < len; k++)
			sum = sum + rsp_buf[k];
		rsp_buf[len - 1] = sum[15:8];
		rsp_buf[len] = sum[7:0];
		return len + 1;
	endfunction

	function automatic int refuse(input logic [15:0] reason, input logic bc);
		put_header(RtNack, (cap_cc == CcGet) ? CcGetResp : CcSetResp, cap_pid);
		pd16(0, reason);
		return seal(2, bc);
	endfunction

	function automatic int answer(input logic bc);
		logic       is_set;
		logic [7:0] d0;
		logic [15:0] a;
		logic [15:0] slot_id[4];
		is_set = (cap_cc == CcSet);
		d0 = cap_head[15:8];
		a = cap_head;
		slot_id = '{16'h0205, 16'h0211, 16'h0206, 16'hFFFF};
		if (cap_sd != 16'h0)
			return refuse(NrSubdev, bc);
		case (cap_pid)
			PidSupported, PidDevInfo, PidModel, PidMfr, PidSwLabel, PidSlotInfo: begin
				if (is_set)
					return refuse(NrClass, bc);
				if (cap_dl != 8'd0)
					return refuse(NrFormat, bc);
				put_header(RtAck, CcGetResp, cap_pid);
				case (cap_pid)
					PidSupported: begin
						pd16(0, PidModel); pd16(2, PidMfr); pd16(4, PidPers);
						pd16(6, PidPersDesc); pd16(8, PidSlotInfo);
						return seal(10, bc);
					end
					PidDevInfo: begin
						pd16(0, 16'h0100); pd16(2, 16'h0); pd16(4, 16'h0101);
						pd16(6, 16'h0); pd16(8, sw_rev);
						pd16(10, 16'd4); pd(12, 8'd1); pd(13, 8'd1);
						pd16(14, {6'd0, dmx_addr}); pd16(16, 16'h0); pd(18, 8'h0);
						return seal(19, bc);
					end
					PidModel: begin
						pd_label(0, 0, 11);
						return seal(11, bc);
					end
					PidMfr: begin
						pd_label(0, 11, 4);
						return seal(4, bc);
					end
					PidSwLabel: begin
						pd_label(0, 15, 3);
						return seal(3, bc);
					end
					default: begin
						for (int s = 0; s < 4; s++) begin
							pd16(5 * s, s[15:0]);
							pd(5 * s + 2, 8'h00);
							pd16(5 * s + 3, slot_id[s]);
						end
						return seal(20, bc);
					end
				endcase
			end
			PidPers: begin
				if (is_set) begin
					if (cap_dl != 8'd1)
						return refuse(NrFormat, bc);
					if (d0 != 8'd1)
						return refuse(NrRange, bc);
					put_header(RtAck, CcSetResp, cap_pid);
					return seal(0, bc);
				end
				if (cap_dl != 8'd0)
					return refuse(NrFormat, bc);
				put_header(RtAck, CcGetResp, cap_pid);
				pd(0, 8'd1); pd(1, 8'd1);
				return seal(2, bc);
			end
			PidPersDesc: begin
				if (is_set)
					return refuse(NrClass, bc);
				if (cap_dl != 8'd1)
					return refuse(NrFormat, bc);
				if (d0 != 8'd1)
					return refuse(NrRange, bc);
				put_header(RtAck, CcGetResp, cap_pid);
				pd(0, 8'd1); pd16(1, 16'd4); pd_label(3, 18, 11);
				return seal(14, bc);
			end
			PidStartAddr: begin
				if (is_set) begin
					if (cap_dl != 8'd2)
						return refuse(NrFormat, bc);
					if (a == 16'd0 || a > 16'd512)
						return refuse(NrRange, bc);
					dmx_addr = a[9:0];
					put_header(RtAck, CcSetResp, cap_pid);
					return seal(0, bc);
				end
				if (cap_dl != 8'd0)
					return refuse(NrFormat, bc);
				put_header(RtAck, CcGetResp, cap_pid);
				pd16(0, {6'd0, dmx_addr});
				return seal(2, bc);
			end
			PidIdentify: begin
				if (is_set) begin
					if (cap_dl != 8'd1)
						return refuse(NrFormat, bc);
					if (d0 > 8'd1)
						return refuse(NrRange, bc);
					ident_flag = (d0 == 8'd1);
					put_header(RtAck, CcSetResp, cap_pid);
					return seal(0, bc);
				end
				if (cap_dl != 8'd0)
					return refuse(NrFormat, bc);
				put_header(RtAck, CcGetResp, cap_pid);
				pd(0, {7'd0, ident_flag});
				return seal(1, bc);
			end
			default: return refuse(NrUnknownPid, bc);
		endcase
	endfunction

	function automatic void take_request_word(input logic [7:0] b, input logic l);
		int          n;
		int          cnt;
		logic        bc;
		logic [47:0] own;
		logic [47:0] mbc;
		rsp_word_t   w;
		bc = 1'b0;
		case (rx_cnt)
			8'd0: begin
				cap_ss = b;
				cap_dst = '0; cap_src = '0; cap_tn = '0; cap_cc = '0;
				cap_sd = '0; cap_pid = '0; cap_dl = '0; cap_head = '0;
			end
			8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7: cap_dst = {cap_dst[39:0], b};
			8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13: cap_src = {cap_src[39:0], b};
			8'd14: cap_tn = b;
			8'd17, 8'd18: cap_sd = {cap_sd[7:0], b};
			8'd19: cap_cc = b;
			8'd20, 8'd21: cap_pid = {cap_pid[7:0], b};
			8'd22: cap_dl = b;
			8'd23: cap_head = {b, 8'h00};
			8'd24: cap_head[7:0] = b;
			default: ;
		endcase
		if (rx_cnt != 8'hFF)
			rx_cnt = rx_cnt + 8'd1;
		if (!l)
			return;
		n = rx_cnt;
		rx_cnt = 8'd0;
		if (n < 23 || cap_ss != SubStartRdm)
			return;
		own = {own_mfr, own_dev};
		mbc = {own_mfr, 32'hFFFF_FFFF};
		if (cap_dst != own) begin
			if (cap_dst == 48'hFFFF_FFFF_FFFF || cap_dst == mbc)
				bc = 1'b1;
			else
				return;
		end
		cnt = answer(bc);
		for (int k = 0; k < cnt; k++) begin
			w.b = rsp_buf[k];
			w.l = (k + 1 == cnt);
			w.ident = ident_flag;
			w.addr = dmx_addr;
			rsp_words_q.push_back(w);
		end
	endfunction

	task automatic push_frame(input logic [7:0] ss, input logic [47:0] dst,
			input logic [7:0] cc, input logic [15:0] pid, input logic [15:0] sd,
			input logic [7:0] dl, input int nd, input logic [7:0] d0,
			input logic [7:0] d1, input int cut);
		logic [7:0] frm[$];
		req_word_t  w;
		int         total;
		frm.push_back(ss);
		frm.push_back(8'(24 + nd));
		for (int k = 0; k < 6; k++)
			frm.push_back(dst[40 - 8 * k +: 8]);
		for (int k = 0; k < 6; k++)
			frm.push_back(8'($urandom));
		frm.push_back(8'($urandom));
		frm.push_back(8'($urandom_range(1, 4)));
		frm.push_back(8'h00);
		frm.push_back(sd[15:8]);
		frm.push_back(sd[7:0]);
		frm.push_back(cc);
		frm.push_back(pid[15:8]);
		frm.push_back(pid[7:0]);
		frm.push_back(dl);
		for (int k = 0; k < nd; k++)
			frm.push_back(k == 0 ? d0 : (k == 1 ? d1 : 8'($urandom)));
		frm.push_back(8'($urandom));
		frm.push_back(8'($urandom));
		total = (cut > 0 && cut < frm.size()) ? cut : frm.size();
		for (int k = 0; k < total; k++) begin
			w.b = frm[k];
			w.l = (k == total - 1);
			req_words_q.push_back(w);
		end
		phase_bytes += total;
	endtask

	task automatic push_noise();
		req_word_t w;
		int        n;
		n = $urandom_range(1, 12);
		for (int k = 0; k < n; k++) begin
			w.b = 8'($urandom);
			w.l = (k == n - 1);
			req_words_q.push_back(w);
		end
		phase_bytes += n;
	endtask

	task automatic push_random_frame();
		logic [15:0] pids[10];
		logic [47:0] dst;
		logic [7:0]  ss;
		logic [7:0]  cc;
		logic [15:0] pid;
		logic [15:0] sd;
		logic [7:0]  dl;
		logic [15:0] a;
		int          nd;
		int          r;
		pids = '{PidSupported, PidDevInfo, PidModel, PidMfr, PidSwLabel, PidPers,
			PidPersDesc, PidStartAddr, PidSlotInfo, PidIdentify};
		r = $urandom_range(0, 9);
		case (r)
			6: dst = 48'hFFFF_FFFF_FFFF;
			7: dst = {own_mfr, 32'hFFFF_FFFF};
			8: dst = {16'($urandom), 32'($urandom)};
			default: dst = {own_mfr, own_dev};
		endcase
		ss = ($urandom_range(0, 19) == 0) ? 8'($urandom) : SubStartRdm;
		pid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pids[$urandom_range(0, 9)];
		r = $urandom_range(0, 19);
		cc = (r < 9) ? CcGet : (r < 18) ? CcSet : 8'($urandom);
		sd = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'h0;
		if ($urandom_range(0, 9) == 0)
			dl = 8'($urandom);
		else
			dl = 8'($urandom_range(0, 2));
		nd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : ((dl > 8) ? 8 : dl);
		a = 16'($urandom_range(0, 600));
		if (pid == PidStartAddr && $urandom_range(0, 3) != 0)
			push_frame(ss, dst, cc, pid, sd, dl, nd, a[15:8], a[7:0], 0);
		else
			push_frame(ss, dst, cc, pid, sd, dl, nd, 8'($urandom_range(0, 2)),
				8'($urandom), ($urandom_range(0, 11) == 0) ? $urandom_range(1, 22) : 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		case (idx)
			CfgMfr: own_mfr = v[15:0];
			CfgDev: own_dev = v;
			CfgSw: sw_rev = v[15:0];
			default: dmx_addr = (v[9:0] == 10'd0) ? 10'd1 :
				(v[9:0] > MaxStartAddr) ? MaxStartAddr : v[9:0];
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic drain();
		while (req_words_q.size() != 0 || start || rsp_words_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic directed_frames();
		logic [47:0] me;
		logic [7:0]  nul;
		me = {own_mfr, own_dev};
		nul = 8'h00;
		push_frame(SubStartRdm, me, CcGet, PidDevInfo, 16'h0, 8'd0, 0, nul, nul, 0);
		push_frame(SubStartRdm, me, CcGet, PidSlotInfo, 16'h0, 8'd0, 0, nul, nul, 0);
		push_frame(SubStartRdm, me, CcSet, PidSupported, 16'h0, 8'd0, 0, nul, nul, 0);
		push_frame(SubStartRdm, me, CcGet, PidModel, 16'h0, 8'd1, 1, nul, nul, 0);
		push_frame(SubStartRdm, me, CcGet, PidPersDesc, 16'h0, 8'd1, 1, 8'd1, nul, 0);
		push_frame(SubStartRdm, me, CcSet, PidStartAddr, 16'h0, 8'd2, 2, 8'h02, 8'h00, 0);
		push_frame(SubStartRdm, me, CcSet, PidStartAddr, 16'h0, 8'd2, 2, 8'hFF, 8'hFF, 0);
		push_frame(SubStartRdm, me, CcSet, PidIdentify, 16'h0, 8'd1, 1, 8'd1, nul, 0);
		push_frame(SubStartRdm, me, CcGet, PidIdentify, 16'hFFFF, 8'd0, 0, nul, nul, 0);
		push_frame(SubStartRdm, me, 8'h55, 16'hFFFF, 16'h0, 8'd0, 0, nul, nul, 0);
		push_frame(8'hCC, me, CcGet, PidModel, 16'h0, 8'd0, 0, nul, nul, 0);
		push_frame(SubStartRdm, 48'hFFFF_FFFF_FFFF, CcSet, PidStartAddr, 16'h0, 8'd2, 2,
			8'h00, 8'd100, 0);
		push_frame(SubStartRdm, me, CcGet, PidDevInfo, 16'h0, 8'd0, 0, nul, nul, 20);
		push_frame(SubStartRdm, me, CcGet, PidStartAddr, 16'h0, 8'd0, 8, nul, nul, 0);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				take_request_word(rx_byte, rx_last);
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (req_words_q.size() != 0) begin
					rx_byte <= req_words_q[0].b;
					rx_last <= req_words_q[0].l;
					void'(req_words_q.pop_front());
					start <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && tx_valid) begin
			if (rsp_words_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response word %h last %b", tx_byte, tx_last);
			end else begin
				if (tx_byte !== rsp_words_q[0].b || tx_last !== rsp_words_q[0].l ||
						identify_on !== rsp_words_q[0].ident ||
						start_address !== rsp_words_q[0].addr) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
							rsp_words_q[0].b, rsp_words_q[0].l, rsp_words_q[0].ident,
							rsp_words_q[0].addr, tx_byte, tx_last, identify_on,
							start_address);
				end
				void'(rsp_words_q.pop_front());
			end
		end
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		rx_byte = 8'h00;
		rx_last = 1'b0;
		wr_en = 1'b0;
		wr_index = CfgMfr;
		wr_data = 32'h0;
		mismatches = 0;
		burst_left = 1;
		gap_left = 0;
		own_mfr = 16'h0;
		own_dev = 32'h0;
		sw_rev = 16'h0;
		rx_cnt = 8'h0;
		cap_ss = '0; cap_dst = '0; cap_src = '0; cap_tn = '0; cap_cc = '0;
		cap_sd = '0; cap_pid = '0; cap_dl = '0; cap_head = '0;
		dmx_addr = 10'd1;
		ident_flag = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(CfgMfr, 32'h0);
					write_reg(CfgDev, 32'h0);
					write_reg(CfgSw, 32'h0);
					write_reg(CfgStart, 32'h0);
				end
				1: begin
					write_reg(CfgMfr, 32'h0000_FFFF);
					write_reg(CfgDev, 32'hFFFF_FFFF);
					write_reg(CfgSw, 32'h0000_FFFF);
					write_reg(CfgStart, 32'h0000_03FF);
				end
				2: begin
					write_reg(CfgMfr, $urandom);
					write_reg(CfgDev, $urandom);
					write_reg(CfgSw, $urandom);
					write_reg(CfgStart, 32'd512);
				end
				default: begin
					write_reg(CfgMfr, $urandom);
					write_reg(CfgDev, $urandom);
					write_reg(CfgSw, $urandom);
					write_reg(CfgStart, $urandom_range(1, 600));
				end
			endcase
			phase_bytes = 0;
			if (ph == 0)
				directed_frames();
			while (phase_bytes < 40) begin
				if ($urandom_range(0, 9) == 0)
					push_noise();
				else
					push_random_frame();
			end
			drain();
		end
		if (mismatches == 0 && rsp_words_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
src/rdm_pkg.sv
src/rdm_rx.sv
src/rdm_resp.sv
src/rdm_responder_unit.sv
src/rdm_checker.sv
test/tb_rdm_responder_unit.sv
